### hdl/ipoc_pkg.sv
// Shared types and constants for the int64 power overflow check block.
package ipoc_pkg;

   localparam int unsigned WordWidth = 64;

   localparam logic [WordWidth-1:0] WORD_ONE  = 64'h0000_0000_0000_0001;
   localparam logic [WordWidth-1:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WordWidth-1:0] SIGNED_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic signed [WordWidth-1:0] base_value;
      logic [WordWidth-1:0]        exponent_value;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] power_result;
      logic                        overflowed;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // take a new item
      logic mul_start;  // launch one checked multiply
      logic mul_sq;     // 1: square -> square, 0: accumulator * square -> accumulator
      logic shift;      // drop the exponent LSB
      logic finish;     // move the result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic e_zero;
      logic e_gt1;
      logic e_odd;
      logic mul_done;
      logic rsp_free;
   } status_type;

endpackage

### hdl/ipoc_mul.sv
// Multi-cycle 64x64 signed multiply with signed 64-bit overflow check.
module ipoc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product,
   output logic        ovf
);
   import ipoc_pkg::*;

   logic [63:0]  ma_ff, mb_ff;
   logic         neg_ff;
   logic         busy_ff;
   logic [1:0]   cnt_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pp_sh_ff;
   logic         pp_vld_ff;
   logic         pp_last_ff;
   logic         fin_ff;
   logic [127:0] prod_ff;

   logic [31:0]  a_half, b_half;
   logic [127:0] pp_aligned;
   logic [63:0]  lo, hi, limit;

   // Partial product select: cnt bit 0 picks the half of a, bit 1 the half of b
   assign a_half = cnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half = cnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (pp_sh_ff)
         2'd0:    pp_aligned = {64'd0, pp_ff};
         2'd1:    pp_aligned = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_aligned = {pp_ff, 64'd0};
         default: pp_aligned = 128'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= 2'd0;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
         fin_ff     <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
         pp_vld_ff  <= busy_ff;
         pp_last_ff <= busy_ff && (cnt_ff == 2'd3);
         fin_ff     <= pp_vld_ff && pp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff   <= a[63] ? (~a + WORD_ONE) : a;
         mb_ff   <= b[63] ? (~b + WORD_ONE) : b;
         neg_ff  <= a[63] ^ b[63];
         prod_ff <= 128'd0;
      end else if (pp_vld_ff) begin
         prod_ff <= prod_ff + pp_aligned;
      end
      if (busy_ff) begin
         pp_ff    <= {32'd0, a_half} * {32'd0, b_half};
         pp_sh_ff <= {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
      end
   end

   assign lo      = prod_ff[63:0];
   assign hi      = prod_ff[127:64];
   assign limit   = neg_ff ? SIGNED_MIN : SIGNED_MAX;
   assign done    = fin_ff;
   assign product = neg_ff ? (~lo + WORD_ONE) : lo;
   assign ovf     = (hi != 64'd0) || (lo > limit);

endmodule

### hdl/ipoc_dp.sv
// Datapath: operand registers, shared multiplier, saturation and result register.
module ipoc_dp (
   input  logic                clock,
   input  logic                reset,
   input  ipoc_pkg::cmd_type   cmd,
   output ipoc_pkg::status_type status,
   input  ipoc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ipoc_pkg::rsp_type   rsp_data,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);
   import ipoc_pkg::*;

   logic        sat_mode_ff;
   logic [63:0] acc_ff, sq_ff, e_ff;
   logic        ovf_ff;
   logic        base_neg_ff, exp_odd_ff;
   logic        dst_sq_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic [63:0] mul_a, mul_product;
   logic        mul_done, mul_ovf;
   logic [63:0] final_value;

   assign mul_a = cmd.mul_sq ? sq_ff : acc_ff;

   ipoc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (sq_ff),
      .done    (mul_done),
      .product (mul_product),
      .ovf     (mul_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sat_mode_ff <= csr_wr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (ovf_ff && sat_mode_ff) begin
         final_value = (base_neg_ff && exp_odd_ff) ? SIGNED_MIN : SIGNED_MAX;
      end else begin
         final_value = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff      <= WORD_ONE;
         sq_ff       <= req_data.base_value;
         e_ff        <= req_data.exponent_value;
         ovf_ff      <= 1'b0;
         base_neg_ff <= req_data.base_value[63];
         exp_odd_ff  <= req_data.exponent_value[0];
      end else begin
         if (mul_done) begin
            if (dst_sq_ff) begin
               sq_ff <= mul_product;
            end else begin
               acc_ff <= mul_product;
            end
            ovf_ff <= ovf_ff | mul_ovf;
         end
         if (cmd.shift) begin
            e_ff <= e_ff >> 1;
         end
      end
      if (cmd.mul_start) begin
         dst_sq_ff <= cmd.mul_sq;
      end
      if (cmd.finish) begin
         rsp_data_ff.power_result <= final_value;
         rsp_data_ff.overflowed   <= ovf_ff;
      end
   end

   assign status.e_zero   = (e_ff == 64'd0);
   assign status.e_gt1    = |e_ff[63:1];
   assign status.e_odd    = e_ff[0];
   assign status.mul_done = mul_done;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/ipoc_ctrl.sv
// Controller: sequences the square-and-multiply scan over the exponent bits.
module ipoc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ipoc_pkg::status_type status,
   output ipoc_pkg::cmd_type    cmd
);
   import ipoc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_WACC  = 3'd2;
   localparam logic [2:0] S_WSQ   = 3'd3;
   localparam logic [2:0] S_WFIN  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.e_zero) begin
               state_in = S_OUT;
            end else if (status.e_gt1) begin
               cmd.mul_start = 1'b1;
               if (status.e_odd) begin
                  state_in = S_WACC;
               end else begin
                  cmd.mul_sq = 1'b1;
                  state_in   = S_WSQ;
               end
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = S_WFIN;
            end
         end
         S_WACC: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sq    = 1'b1;
               state_in      = S_WSQ;
            end
         end
         S_WSQ: begin
            if (status.mul_done) begin
               cmd.shift = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_WFIN: begin
            if (status.mul_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### hdl/int64_power_overflow_check_core.sv
// Top level of the signed 64-bit power unit with overflow flag.
//
// Computes base_value ** exponent_value by scanning the exponent from its LSB:
// for each bit below the top set bit, multiply the accumulator by the running
// square when the bit is set, then square the running square; one last multiply
// of accumulator by square closes the scan. Every multiply wraps to 64 bits and
// flags overflow when the exact signed product leaves the signed 64-bit range.
// With csr saturate mode set, an overflowed result becomes the signed maximum,
// or the signed minimum for a negative base with an odd exponent. An exponent of
// zero gives 1 with no overflow. One item is in work at a time. Each checked
// multiply runs on a single shared 32x32 multiplier as four partial products.
// The result sits in an output register, so the next transfer is accepted while
// a finished result still waits on rsp_stall. Write csr only while idle.
module int64_power_overflow_check_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ipoc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipoc_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import ipoc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: decides which multiply runs next and when the result leaves
   ipoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Operand registers, shared multiplier, saturation and output register
   ipoc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // A transfer in makes the block busy on the next cycle
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after input transfer");

   // The multiplier only finishes while an item is in work
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> req_stall)
      else $error("multiply completed while idle");

   // A new result appears only after the controller commits one
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result shown without finish command");

   // Load never coincides with a multiply launch or a finish
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.mul_start || cmd.finish)))
      else $error("load overlaps other commands");

endmodule

### sim/tb_int64_power_overflow_check_core.sv
// Self-checking testbench for the signed 64-bit power unit with overflow flag.
`timescale 1ns / 1ps

module tb_int64_power_overflow_check_core;
   import ipoc_pkg::*;

   // Run-length guards, in clock cycles
   localparam int unsigned CycleLimit     = 2_000_000;
   localparam int unsigned LongHoldCycles = 2500;
   localparam int unsigned SettleCycles   = 900;
   localparam int unsigned MaxIdle        = 18;

   // Tracks expected power results in transfer order and checks each response.
   class power_scoreboard;
      bit          saturate;
      int unsigned mismatches;
      rsp_type     expected_q[$];
      req_type     source_q[$];

      function new();
         saturate   = 1'b0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Wrapped product; raise ovf when the exact signed product leaves 64 bits.
      function logic [WordWidth-1:0] checked_mul(logic [WordWidth-1:0] a,
                                                 logic [WordWidth-1:0] b,
                                                 inout bit ovf);
         logic signed [2*WordWidth-1:0] prod;
         prod = $signed({{WordWidth{a[WordWidth-1]}}, a})
              * $signed({{WordWidth{b[WordWidth-1]}}, b});
         if (prod[2*WordWidth-1:WordWidth-1] != {(WordWidth+1){prod[WordWidth-1]}})
            ovf = 1'b1;
         return prod[WordWidth-1:0];
      endfunction

      // Square-and-multiply from the exponent LSB, closing with one last multiply.
      function rsp_type predict_power(req_type item);
         logic [WordWidth-1:0] acc;
         logic [WordWidth-1:0] sq;
         logic [WordWidth-1:0] e;
         bit                   ovf;
         rsp_type              r;
         acc = WORD_ONE;
         sq  = item.base_value;
         e   = item.exponent_value;
         ovf = 1'b0;
         if (e != '0) begin
            while (e > WORD_ONE) begin
               if (e[0])
                  acc = checked_mul(acc, sq, ovf);
               sq = checked_mul(sq, sq, ovf);
               e  = e >> 1;
            end
            acc = checked_mul(acc, sq, ovf);
         end
         if (ovf && saturate)
            acc = (item.base_value[WordWidth-1] && item.exponent_value[0]) ?
                  SIGNED_MIN : SIGNED_MAX;
         r.power_result = acc;
         r.overflowed   = ovf;
         return r;
      endfunction

      function void note_request(req_type item);
         source_q.push_back(item);
         expected_q.push_back(predict_power(item));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         req_type item;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: power %h ovf %b",
                        got.power_result, got.overflowed);
            return;
         end
         want = expected_q.pop_front();
         item = source_q.pop_front();
         if (got.power_result !== want.power_result || got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch base %h exp %h: power %h ovf %b, expected power %h ovf %b",
                        item.base_value, item.exponent_value, got.power_result,
                        got.overflowed, want.power_result, want.overflowed);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Shared by sender and receiver: 0 runs a stretch with no idle cycles
   bit          idle_on = 1'b1;
   int unsigned cycle_count = 0;

   power_scoreboard power_sb = new();

   int64_power_overflow_check_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sample both channels on the edge, before any of this step's updates land.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         power_sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall)
         power_sb.check_response(rsp_data);
   end

   // Receiver: draw a stall per transfer; twice hold off long enough that the
   // block fills up and pushes back on the sender.
   initial begin : receiver
      int unsigned hold;
      int unsigned transfers;
      transfers = 0;
      forever begin
         if (transfers == 30 || transfers == 250)
            hold = LongHoldCycles;
         else
            hold = idle_on ? $urandom_range(0, MaxIdle) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         transfers++;
      end
   end

   // Watchdog: fail the run if it has not finished by the cycle limit.
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("int64_power_overflow_check_core test failed");
      $finish;
   end

   // Offer one transfer after a random gap; keep valid high when the gap is zero.
   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every expected result is back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (power_sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the mode register while the block is idle and track it in the predictor.
   task automatic write_saturate(input bit mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      power_sb.saturate = mode;
   endtask

   function automatic req_type make_request(logic [WordWidth-1:0] b,
                                            logic [WordWidth-1:0] x);
      req_type item;
      item.base_value     = b;
      item.exponent_value = x;
      return item;
   endfunction

   // Corner cases: zero exponent (0^0 too), zero base, unit bases with huge
   // exponents, the edge of the signed range from both sides, and overflows
   // that saturate to either limit.
   task automatic run_corners();
      req_type corner_q[$];
      corner_q.push_back(make_request('0, '0));
      corner_q.push_back(make_request(SIGNED_MIN, '0));
      corner_q.push_back(make_request('0, 64'd5));
      corner_q.push_back(make_request('1, '1));
      corner_q.push_back(make_request(WORD_ONE, '1));
      corner_q.push_back(make_request(64'd2, 64'd62));
      corner_q.push_back(make_request(64'd2, 64'd63));
      corner_q.push_back(make_request(-64'sd2, 64'd63));
      corner_q.push_back(make_request(-64'sd2, 64'd65));
      corner_q.push_back(make_request(SIGNED_MAX, 64'd2));
      corner_q.push_back(make_request(SIGNED_MIN, WORD_ONE));
      corner_q.push_back(make_request(64'd3, 64'd40));
      corner_q.push_back(make_request(-64'sd3, 64'd41));
      foreach (corner_q[i])
         send_request(corner_q[i]);
   endtask

   // Weight toward bases and exponents whose powers land near the signed limits.
   function automatic req_type random_request();
      int unsigned          pick;
      int unsigned          k;
      logic [WordWidth-1:0] b;
      logic [WordWidth-1:0] x;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 62);
      if (pick < 35) begin
         b = 64'($urandom_range(0, 40)) - 64'd20;
         x = 64'($urandom_range(0, 70));
      end else if (pick < 55) begin
         b = WORD_ONE << k;
         case ($urandom_range(0, 3))
            0: b = b;
            1: b = -b;
            2: b = b + WORD_ONE;
            default: b = -b - WORD_ONE;
         endcase
         x = 64'($urandom_range(0, 66));
      end else if (pick < 68) begin
         case ($urandom_range(0, 3))
            0: b = '0;
            1: b = WORD_ONE;
            2: b = '1;
            default: b = -64'sd2;
         endcase
         x = {$urandom, $urandom};
      end else if (pick < 80) begin
         b = {$urandom, $urandom};
         x = 64'($urandom_range(0, 3));
      end else begin
         b = {$urandom, $urandom};
         x = {$urandom, $urandom};
      end
      return make_request(b, x);
   endfunction

   task automatic run_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         // Switch idling on or off now and then, for stretches at full rate
         if (n % 40 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         send_request(random_request());
      end
      idle_on = 1'b1;
   endtask

   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Wrapped results first, then the same corners saturated
      write_saturate(1'b0);
      run_corners();
      wait_for_results();
      write_saturate(1'b1);
      run_corners();
      wait_for_results();

      // Random phases, alternating the mode
      run_random(140);
      wait_for_results();
      write_saturate(1'b0);
      run_random(140);
      wait_for_results();
      write_saturate(1'b1);
      run_random(140);
      wait_for_results();

      // Let any stray result show up before the verdict
      repeat (SettleCycles) @(posedge clock);
      if (power_sb.mismatches == 0)
         $display("int64_power_overflow_check_core test passed");
      else
         $display("int64_power_overflow_check_core test failed");
      $finish;
   end

endmodule

### int64_power_overflow_check_core.f
hdl/ipoc_pkg.sv
hdl/ipoc_mul.sv
hdl/ipoc_dp.sv
hdl/ipoc_ctrl.sv
hdl/int64_power_overflow_check_core.sv
sim/tb_int64_power_overflow_check_core.sv
